// ----- design/sse3_vector_float_unit_top_macros.svh -----
// assertion macros for the vector float unit
// used by the queue and top level files
`ifndef SSE3_VECTOR_FLOAT_UNIT_TOP_MACROS_SVH
`define SSE3_VECTOR_FLOAT_UNIT_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define SVF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication with the consequence checked on the next clock edge
`define SVF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/svfu_pkg.sv -----
// types, opcodes and pipelined float add stages for the vector float unit
// no dependencies
package svfu_pkg;

    typedef enum logic [3:0] {
        OP_SLDUP    = 4'd0,
        OP_DDUP     = 4'd1,
        OP_SHDUP    = 4'd2,
        OP_LDDQU    = 4'd3,
        OP_HADDPD   = 4'd4,
        OP_HADDPS   = 4'd5,
        OP_HSUBPD   = 4'd6,
        OP_HSUBPS   = 4'd7,
        OP_ADDSUBPD = 4'd8,
        OP_ADDSUBPS = 4'd9
    } op_t;

    localparam logic [63:0] D_DEFNAN = 64'hFFF8000000000000;
    localparam logic [31:0] S_DEFNAN = 32'hFFC00000;
    localparam logic [63:0] D_QUIET  = 64'h0008000000000000;
    localparam logic [31:0] S_QUIET  = 32'h00400000;

    typedef struct packed {
        logic [3:0]  operation;
        logic        wide;
        logic [3:0]  dest_reg;
        logic [63:0] src_lane0;
        logic [63:0] src_lane1;
        logic [63:0] src_lane2;
        logic [63:0] src_lane3;
        logic [63:0] vsrc_lane0;
        logic [63:0] vsrc_lane1;
        logic [63:0] vsrc_lane2;
        logic [63:0] vsrc_lane3;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_lane0;
        logic [63:0] result_lane1;
        logic [63:0] result_lane2;
        logic [63:0] result_lane3;
        logic [3:0]  dest_out;
        logic        wide_out;
    } out_item_t;

    // classified work: per lane operand pairs for the back end
    typedef struct packed {
        logic           dbl;       // double precision adders
        logic           arith;     // use adders, else copy
        logic [3:0][63:0] a;       // first operands
        logic [3:0][63:0] b;       // second operands
        logic [3:0][1:0]  sub;     // per single half (dbl uses bit 0)
        logic [3:0][63:0] copy;
        logic           wide;
        logic [3:0]     dest;
    } work_t;

    // control carried alongside the adder pipeline
    typedef struct packed {
        logic             dbl;
        logic             arith;
        logic [3:0][63:0] copy;
        logic             wide;
        logic [3:0]       dest;
    } ctrl_t;

    // adder stage one output: special operands resolved, operands aligned
    typedef struct packed {
        logic        spec;
        logic [63:0] spec_val;
        logic        sr;
        logic        zsign;
        logic        eff;
        logic [10:0] el;
        logic [55:0] xa;
        logic [55:0] xs;
    } d_align_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sr;
        logic        zsign;
        logic        eff;
        logic [7:0]  el;
        logic [26:0] xa;
        logic [26:0] xs;
    } s_align_t;

    // adder stage two output: raw sum and leading zero count
    typedef struct packed {
        logic        spec;
        logic [63:0] spec_val;
        logic        sr;
        logic        zsign;
        logic [10:0] el;
        logic [56:0] sum;
        logic [5:0]  lz;
    } d_sum_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sr;
        logic        zsign;
        logic [7:0]  el;
        logic [27:0] sum;
        logic [4:0]  lz;
    } s_sum_t;

    typedef struct packed {
        d_align_t       d;
        s_align_t [1:0] s;
    } lane_align_t;

    typedef struct packed {
        d_sum_t       d;
        s_sum_t [1:0] s;
    } lane_sum_t;

    // double add/sub, stage one: nan/inf handling, swap, align with guard bits
    function automatic d_align_t d_align(input logic [63:0] a, input logic [63:0] b,
                                         input logic sub);
        d_align_t    o;
        logic        sa, sb, swp;
        logic [10:0] ea, eb;
        logic [52:0] ma, mb;
        logic [55:0] xb;
        logic [11:0] d;
        o = '0;
        sa = a[63]; sb = b[63] ^ sub;
        ea = a[62:52]; eb = b[62:52];
        o.zsign = sa & sb;
        o.eff   = sa ^ sb;
        o.spec  = 1'b1;
        if (ea == 11'h7FF && a[51:0] != 0) o.spec_val = a | D_QUIET;
        else if (eb == 11'h7FF && b[51:0] != 0) o.spec_val = b | D_QUIET;
        else if (ea == 11'h7FF && eb == 11'h7FF)
            o.spec_val = (sa != sb) ? D_DEFNAN : {sa, 11'h7FF, 52'd0};
        else if (ea == 11'h7FF) o.spec_val = {sa, 11'h7FF, 52'd0};
        else if (eb == 11'h7FF) o.spec_val = {sb, 11'h7FF, 52'd0};
        else o.spec = 1'b0;
        ma = {ea != 0, a[51:0]};
        mb = {eb != 0, b[51:0]};
        if (ea == 0) ea = 11'd1;
        if (eb == 0) eb = 11'd1;
        swp = (eb > ea) || (eb == ea && mb > ma);
        if (swp) begin
            o.sr = sb; o.el = eb;
            o.xa = {mb, 3'b000}; xb = {ma, 3'b000};
            d = {1'b0, eb} - {1'b0, ea};
        end else begin
            o.sr = sa; o.el = ea;
            o.xa = {ma, 3'b000}; xb = {mb, 3'b000};
            d = {1'b0, ea} - {1'b0, eb};
        end
        if (d > 12'd55) o.xs = {55'd0, xb != 0};
        else o.xs = (xb >> d[5:0]) | {55'd0, (xb & ((56'd1 << d[5:0]) - 56'd1)) != 0};
        return o;
    endfunction

    // double add/sub, stage two: add or subtract and count leading zeros
    function automatic d_sum_t d_sum(input d_align_t i);
        d_sum_t o;
        logic   found;
        o.spec     = i.spec;
        o.spec_val = i.spec_val;
        o.sr       = i.sr;
        o.zsign    = i.zsign;
        o.el       = i.el;
        o.sum = i.eff ? {1'b0, i.xa} - {1'b0, i.xs} : {1'b0, i.xa} + {1'b0, i.xs};
        o.lz  = '0;
        found = 1'b0;
        for (int k = 56; k >= 0; k--) begin
            if (o.sum[k]) found = 1'b1;
            else if (!found) o.lz = o.lz + 6'd1;
        end
        return o;
    endfunction

    // double add/sub, stage three: normalise, round to nearest even, pack
    function automatic logic [63:0] d_round(input d_sum_t i);
        logic [12:0] e;
        logic [56:0] n;
        logic        rnd;
        logic [53:0] m;
        if (i.spec) return i.spec_val;
        if (i.sum == '0) return {i.zsign, 63'd0};
        e = {2'b0, i.el} + 13'd1;
        n = i.sum;
        // normalise to bit 56 without dropping below exponent 1
        if ({7'd0, i.lz} >= e) begin
            n = n << (e - 13'd1);
            e = 13'd0;
        end else begin
            n = n << i.lz;
            e = e - {7'd0, i.lz};
        end
        // n[56:4] mantissa, n[3] guard, rest sticky
        rnd = n[3] & ((n[2:0] != 0) | n[4]);
        m = {1'b0, n[56:4]} + {53'd0, rnd};
        if (m[53]) begin
            m = m >> 1;
            e = e + 13'd1;
        end
        if (e == 0 && m[52]) e = 13'd1;
        if (e >= 13'd2047) return {i.sr, 11'h7FF, 52'd0};
        return {i.sr, e[10:0], m[51:0]};
    endfunction

    function automatic s_align_t s_align(input logic [31:0] a, input logic [31:0] b,
                                         input logic sub);
        s_align_t    o;
        logic        sa, sb, swp;
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic [26:0] xb;
        logic [8:0]  d;
        o = '0;
        sa = a[31]; sb = b[31] ^ sub;
        ea = a[30:23]; eb = b[30:23];
        o.zsign = sa & sb;
        o.eff   = sa ^ sb;
        o.spec  = 1'b1;
        if (ea == 8'hFF && a[22:0] != 0) o.spec_val = a | S_QUIET;
        else if (eb == 8'hFF && b[22:0] != 0) o.spec_val = b | S_QUIET;
        else if (ea == 8'hFF && eb == 8'hFF)
            o.spec_val = (sa != sb) ? S_DEFNAN : {sa, 8'hFF, 23'd0};
        else if (ea == 8'hFF) o.spec_val = {sa, 8'hFF, 23'd0};
        else if (eb == 8'hFF) o.spec_val = {sb, 8'hFF, 23'd0};
        else o.spec = 1'b0;
        ma = {ea != 0, a[22:0]};
        mb = {eb != 0, b[22:0]};
        if (ea == 0) ea = 8'd1;
        if (eb == 0) eb = 8'd1;
        swp = (eb > ea) || (eb == ea && mb > ma);
        if (swp) begin
            o.sr = sb; o.el = eb; o.xa = {mb, 3'b000}; xb = {ma, 3'b000};
            d = {1'b0, eb} - {1'b0, ea};
        end else begin
            o.sr = sa; o.el = ea; o.xa = {ma, 3'b000}; xb = {mb, 3'b000};
            d = {1'b0, ea} - {1'b0, eb};
        end
        if (d > 9'd26) o.xs = {26'd0, xb != 0};
        else o.xs = (xb >> d[4:0]) | {26'd0, (xb & ((27'd1 << d[4:0]) - 27'd1)) != 0};
        return o;
    endfunction

    function automatic s_sum_t s_sum(input s_align_t i);
        s_sum_t o;
        logic   found;
        o.spec     = i.spec;
        o.spec_val = i.spec_val;
        o.sr       = i.sr;
        o.zsign    = i.zsign;
        o.el       = i.el;
        o.sum = i.eff ? {1'b0, i.xa} - {1'b0, i.xs} : {1'b0, i.xa} + {1'b0, i.xs};
        o.lz  = '0;
        found = 1'b0;
        for (int k = 27; k >= 0; k--) begin
            if (o.sum[k]) found = 1'b1;
            else if (!found) o.lz = o.lz + 5'd1;
        end
        return o;
    endfunction

    function automatic logic [31:0] s_round(input s_sum_t i);
        logic [9:0]  e;
        logic [27:0] n;
        logic        rnd;
        logic [24:0] m;
        if (i.spec) return i.spec_val;
        if (i.sum == '0) return {i.zsign, 31'd0};
        e = {2'b0, i.el} + 10'd1;
        n = i.sum;
        if ({5'd0, i.lz} >= e) begin
            n = n << (e - 10'd1);
            e = 10'd0;
        end else begin
            n = n << i.lz;
            e = e - {5'd0, i.lz};
        end
        rnd = n[3] & ((n[2:0] != 0) | n[4]);
        m = {1'b0, n[27:4]} + {24'd0, rnd};
        if (m[24]) begin
            m = m >> 1;
            e = e + 10'd1;
        end
        if (e == 0 && m[23]) e = 10'd1;
        if (e >= 10'd255) return {i.sr, 8'hFF, 23'd0};
        return {i.sr, e[7:0], m[22:0]};
    endfunction

endpackage

// ----- design/sse3_vector_float_unit_top.sv -----
// path: an accepted word passes the front register, the queue and 3 adder stages to the result ports
// throughput: one instruction per cycle through the pipelined lane adders; stalls only while pop is low
// invalid opcodes are dropped in the front end and give no result
// reset clears all valid state asynchronously; payload registers are not reset
// depends on svfu_pkg, svfu_front, svfu_queue, svfu_back and the macros header
`include "sse3_vector_float_unit_top_macros.svh"
module sse3_vector_float_unit_top (
    input  logic                clk,
    input  logic                rst_n,
    input  svfu_pkg::in_item_t  in_item,
    input  logic                push,
    output logic                full,
    output svfu_pkg::out_item_t out_item,
    output logic                empty,
    input  logic                pop
);

    svfu_pkg::work_t f_work, q_work;
    logic            f_valid, f_ready, q_valid, q_ready, in_ready, res_valid;

    svfu_front u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(push), .in_ready(in_ready),
        .work(f_work), .work_valid(f_valid), .work_ready(f_ready)
    );

    svfu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_work), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_work), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    svfu_back u_back (
        .clk(clk), .rst_n(rst_n), .work(q_work), .work_valid(q_valid), .work_ready(q_ready),
        .res(out_item), .res_valid(res_valid), .res_ready(pop)
    );

    assign full  = !in_ready;
    assign empty = !res_valid;

    `SVF_ASSERT_NEXT(top_hold, !empty && !pop, !empty && $stable(out_item),
        "waiting result changed")
    `SVF_ASSERT(top_full_means_stall, full, f_valid && !f_ready, "full without back-pressure")

endmodule

// ----- design/svfu_front.sv -----
// front end: accepts instructions, drops bad opcodes, routes operands
// depends on svfu_pkg
module svfu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  svfu_pkg::in_item_t in_item,
    input  logic               in_valid,
    output logic               in_ready,
    output svfu_pkg::work_t    work,
    output logic               work_valid,
    input  logic               work_ready
);

    svfu_pkg::work_t work_reg, work_next;
    logic            valid_reg;
    logic [3:0][63:0] s, v;
    logic            good;

    assign s = {in_item.src_lane3, in_item.src_lane2, in_item.src_lane1, in_item.src_lane0};
    assign v = {in_item.vsrc_lane3, in_item.vsrc_lane2, in_item.vsrc_lane1,
                in_item.vsrc_lane0};
    assign good = in_item.operation <= svfu_pkg::OP_ADDSUBPS;
    assign in_ready = !valid_reg || work_ready;

    always_comb
    begin
        work_next = '0;
        work_next.wide = in_item.wide;
        work_next.dest = in_item.dest_reg;
        for (int h = 0; h < 2; h++) begin
            case (in_item.operation)
                svfu_pkg::OP_SLDUP:
                begin
                    work_next.copy[2*h]   = {s[2*h][31:0], s[2*h][31:0]};
                    work_next.copy[2*h+1] = {s[2*h+1][31:0], s[2*h+1][31:0]};
                end
                svfu_pkg::OP_DDUP:
                begin
                    work_next.copy[2*h]   = s[2*h];
                    work_next.copy[2*h+1] = s[2*h];
                end
                svfu_pkg::OP_SHDUP:
                begin
                    work_next.copy[2*h]   = {s[2*h][63:32], s[2*h][63:32]};
                    work_next.copy[2*h+1] = {s[2*h+1][63:32], s[2*h+1][63:32]};
                end
                svfu_pkg::OP_LDDQU:
                begin
                    work_next.copy[2*h]   = s[2*h];
                    work_next.copy[2*h+1] = s[2*h+1];
                end
                svfu_pkg::OP_HADDPD, svfu_pkg::OP_HSUBPD:
                begin
                    work_next.arith = 1'b1;
                    work_next.dbl   = 1'b1;
                    if (in_item.operation == svfu_pkg::OP_HADDPD) begin
                        work_next.a[2*h] = v[2*h+1]; work_next.b[2*h] = v[2*h];
                        work_next.a[2*h+1] = s[2*h+1]; work_next.b[2*h+1] = s[2*h];
                    end else begin
                        work_next.a[2*h] = v[2*h]; work_next.b[2*h] = v[2*h+1];
                        work_next.a[2*h+1] = s[2*h]; work_next.b[2*h+1] = s[2*h+1];
                        work_next.sub[2*h] = 2'b01; work_next.sub[2*h+1] = 2'b01;
                    end
                end
                svfu_pkg::OP_HADDPS, svfu_pkg::OP_HSUBPS:
                begin
                    work_next.arith = 1'b1;
                    // low single of a/b from element pair in lane 2h, high from 2h+1
                    if (in_item.operation == svfu_pkg::OP_HADDPS) begin
                        work_next.a[2*h] = {v[2*h+1][63:32], v[2*h][63:32]};
                        work_next.b[2*h] = {v[2*h+1][31:0], v[2*h][31:0]};
                        work_next.a[2*h+1] = {s[2*h+1][63:32], s[2*h][63:32]};
                        work_next.b[2*h+1] = {s[2*h+1][31:0], s[2*h][31:0]};
                    end else begin
                        work_next.a[2*h] = {v[2*h+1][31:0], v[2*h][31:0]};
                        work_next.b[2*h] = {v[2*h+1][63:32], v[2*h][63:32]};
                        work_next.a[2*h+1] = {s[2*h+1][31:0], s[2*h][31:0]};
                        work_next.b[2*h+1] = {s[2*h+1][63:32], s[2*h][63:32]};
                        work_next.sub[2*h] = 2'b11; work_next.sub[2*h+1] = 2'b11;
                    end
                end
                svfu_pkg::OP_ADDSUBPD:
                begin
                    work_next.arith = 1'b1;
                    work_next.dbl   = 1'b1;
                    work_next.a[2*h] = v[2*h]; work_next.b[2*h] = s[2*h];
                    work_next.a[2*h+1] = v[2*h+1]; work_next.b[2*h+1] = s[2*h+1];
                    work_next.sub[2*h] = 2'b01;
                end
                svfu_pkg::OP_ADDSUBPS:
                begin
                    work_next.arith = 1'b1;
                    work_next.a[2*h] = v[2*h]; work_next.b[2*h] = s[2*h];
                    work_next.a[2*h+1] = v[2*h+1]; work_next.b[2*h+1] = s[2*h+1];
                    work_next.sub[2*h] = 2'b01; work_next.sub[2*h+1] = 2'b01;
                end
                default:
                begin
                    work_next.arith = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid && good;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

    assign work       = work_reg;
    assign work_valid = valid_reg;

endmodule

// ----- design/svfu_queue.sv -----
// two entry queue between front and back ends
// depends on svfu_pkg and the macros header
`include "sse3_vector_float_unit_top_macros.svh"
module svfu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  svfu_pkg::work_t wr_data,
    input  logic            wr_valid,
    output logic            wr_ready,
    output svfu_pkg::work_t rd_data,
    output logic            rd_valid,
    input  logic            rd_ready
);

    svfu_pkg::work_t  mem_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       count_reg;
    logic             wr_en, rd_en;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (wr_en) wptr_reg <= !wptr_reg;
            if (rd_en) rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wptr_reg] <= wr_data;
    end

    `SVF_ASSERT(q_no_overflow, count_reg == 2'd2, !wr_en, "queue write while full")
    `SVF_ASSERT(q_count_range, 1'b1, count_reg != 2'd3, "queue count out of range")
    `SVF_ASSERT_NEXT(q_count_up, wr_en && !rd_en, count_reg == $past(count_reg) + 2'd1,
        "queue count missed a write")

endmodule

// ----- design/svfu_back.sv -----
// back end: three stage pipelined lane adders and copy path into the result register
// depends on svfu_pkg
module svfu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  svfu_pkg::work_t     work,
    input  logic                work_valid,
    output logic                work_ready,
    output svfu_pkg::out_item_t res,
    output logic                res_valid,
    input  logic                res_ready
);

    svfu_pkg::lane_align_t [3:0] al_reg, al_next;
    svfu_pkg::lane_sum_t   [3:0] sm_reg, sm_next;
    svfu_pkg::ctrl_t             c1_reg, c2_reg, c_next;
    svfu_pkg::out_item_t         res_reg, res_next;
    logic                        v1_reg, v2_reg, valid_reg;
    logic                        rdy1, rdy2, rdy3;
    logic [3:0][63:0]            r;

    // each stage moves on when its successor is free or moving
    assign rdy3       = !valid_reg || res_ready;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign work_ready = rdy1;

    always_comb
    begin
        c_next.dbl   = work.dbl;
        c_next.arith = work.arith;
        c_next.copy  = work.copy;
        c_next.wide  = work.wide;
        c_next.dest  = work.dest;
        for (int l = 0; l < 4; l++) begin
            al_next[l].d    = svfu_pkg::d_align(work.a[l], work.b[l], work.sub[l][0]);
            al_next[l].s[0] = svfu_pkg::s_align(work.a[l][31:0], work.b[l][31:0],
                                                work.sub[l][0]);
            al_next[l].s[1] = svfu_pkg::s_align(work.a[l][63:32], work.b[l][63:32],
                                                work.sub[l][1]);
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++) begin
            sm_next[l].d    = svfu_pkg::d_sum(al_reg[l].d);
            sm_next[l].s[0] = svfu_pkg::s_sum(al_reg[l].s[0]);
            sm_next[l].s[1] = svfu_pkg::s_sum(al_reg[l].s[1]);
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++) begin
            if (!c2_reg.arith) r[l] = c2_reg.copy[l];
            else if (c2_reg.dbl) r[l] = svfu_pkg::d_round(sm_reg[l].d);
            else r[l] = {svfu_pkg::s_round(sm_reg[l].s[1]), svfu_pkg::s_round(sm_reg[l].s[0])};
        end
        res_next.result_lane0 = r[0];
        res_next.result_lane1 = r[1];
        res_next.result_lane2 = c2_reg.wide ? r[2] : 64'd0;
        res_next.result_lane3 = c2_reg.wide ? r[3] : 64'd0;
        res_next.dest_out     = c2_reg.dest;
        res_next.wide_out     = c2_reg.wide;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= work_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && work_valid) begin
            al_reg <= al_next;
            c1_reg <= c_next;
        end
        if (rdy2 && v1_reg) begin
            sm_reg <= sm_next;
            c2_reg <= c1_reg;
        end
        if (rdy3 && v2_reg) res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = valid_reg;

endmodule

// ----- bench/tb_sse3_vector_float_unit_top.sv -----
`timescale 1ns / 100ps
// testbench for the sse3 vector float unit: directed and random instructions,
// results checked lane by lane against an in-bench ieee add/sub predictor
// depends on svfu_pkg and sse3_vector_float_unit_top
module tb_sse3_vector_float_unit_top;

    localparam int RANDOM_WORDS = 450;
    localparam int PAUSE_AT     = 220;

    logic                clk;
    logic                rst_n;
    svfu_pkg::in_item_t  in_item;
    logic                push;
    logic                full;
    svfu_pkg::out_item_t out_item;
    logic                empty;
    logic                pop;

    svfu_pkg::in_item_t  pending_words[$];
    svfu_pkg::out_item_t expected_results[$];
    int        errors = 0;
    int        issued = 0;
    int        send_gap = 0;
    int        pop_gap = 0;

    sse3_vector_float_unit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .push     (push),
        .full     (full),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // ---------------- float arithmetic ----------------
    function automatic logic [63:0] dbl_addsub(input logic [63:0] a, input logic [63:0] b,
                                              input bit sub);
        bit  a_nan, b_nan, a_inf, b_inf;
        real x, y;
        a_nan = a[62:52] == 11'h7FF && a[51:0] != 0;
        b_nan = b[62:52] == 11'h7FF && b[51:0] != 0;
        a_inf = a[62:0] == {11'h7FF, 52'd0};
        b_inf = b[62:0] == {11'h7FF, 52'd0};
        if (a_nan) return a | svfu_pkg::D_QUIET;
        if (b_nan) return b | svfu_pkg::D_QUIET;
        if (a_inf && b_inf && ((a[63] ^ b[63]) != sub)) return svfu_pkg::D_DEFNAN;
        x = $bitstoreal(a);
        y = $bitstoreal(b);
        return sub ? $realtobits(x - y) : $realtobits(x + y);
    endfunction

    // widen a single (never a nan here) to double bits
    function automatic logic [63:0] sgl_to_dbl(input logic [31:0] f);
        int          p;
        logic [63:0] m;
        if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, 52'd0};
        if (f[30:23] != 0)
            return {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
        if (f[22:0] == 0) return {f[31], 63'd0};
        p = 0;
        for (int i = 0; i < 23; i++)
            if (f[i]) p = i;
        m = 64'(f[22:0]) << (52 - p);
        return {f[31], 11'(p - 149 + 1023), m[51:0]};
    endfunction

    // round double bits to single, nearest even, subnormals kept
    function automatic logic [31:0] dbl_to_sgl(input logic [63:0] w);
        int          ex, shift;
        logic [63:0] sig, q, rem, half, base, bits;
        if (w[62:52] == 11'h7FF) return {w[63], 8'hFF, 23'd0};
        if (w[62:52] == 0) return {w[63], 31'd0};
        ex  = int'(w[62:52]) - 1023;
        sig = {11'd0, 1'b1, w[51:0]};
        shift = (ex >= -126) ? 29 : 29 + (-126 - ex);
        if (shift > 60) return {w[63], 31'd0};
        q    = sig >> shift;
        half = 64'd1 << (shift - 1);
        rem  = sig & ((64'd1 << shift) - 64'd1);
        if (rem > half || (rem == half && q[0])) q++;
        base = (ex >= -126) ? (64'(ex + 126) << 23) : 64'd0;
        bits = base + q;
        if (bits >= 64'h7F800000) return {w[63], 8'hFF, 23'd0};
        return {w[63], bits[30:0]};
    endfunction

    function automatic logic [31:0] sgl_addsub(input logic [31:0] a, input logic [31:0] b,
                                              input bit sub);
        bit  a_nan, b_nan, a_inf, b_inf;
        real x, y;
        a_nan = a[30:23] == 8'hFF && a[22:0] != 0;
        b_nan = b[30:23] == 8'hFF && b[22:0] != 0;
        a_inf = a[30:0] == {8'hFF, 23'd0};
        b_inf = b[30:0] == {8'hFF, 23'd0};
        if (a_nan) return a | svfu_pkg::S_QUIET;
        if (b_nan) return b | svfu_pkg::S_QUIET;
        if (a_inf && b_inf && ((a[31] ^ b[31]) != sub)) return svfu_pkg::S_DEFNAN;
        x = $bitstoreal(sgl_to_dbl(a));
        y = $bitstoreal(sgl_to_dbl(b));
        return dbl_to_sgl(sub ? $realtobits(x - y) : $realtobits(x + y));
    endfunction

    // result of one instruction; valid low for undefined opcodes
    function automatic svfu_pkg::out_item_t vector_result(input svfu_pkg::in_item_t w,
                                                          output bit valid);
        logic [63:0] s [4];
        logic [63:0] v [4];
        logic [63:0] r [4];
        svfu_pkg::out_item_t o;
        int          b;
        s = '{w.src_lane0, w.src_lane1, w.src_lane2, w.src_lane3};
        v = '{w.vsrc_lane0, w.vsrc_lane1, w.vsrc_lane2, w.vsrc_lane3};
        r = '{64'd0, 64'd0, 64'd0, 64'd0};
        valid = w.operation <= svfu_pkg::OP_ADDSUBPS;
        for (int h = 0; h < (w.wide ? 2 : 1); h++)
        begin
            b = 2 * h;
            case (svfu_pkg::op_t'(w.operation))
                svfu_pkg::OP_SLDUP:
                begin
                    r[b]   = {s[b][31:0], s[b][31:0]};
                    r[b+1] = {s[b+1][31:0], s[b+1][31:0]};
                end
                svfu_pkg::OP_DDUP:
                begin
                    r[b]   = s[b];
                    r[b+1] = s[b];
                end
                svfu_pkg::OP_SHDUP:
                begin
                    r[b]   = {s[b][63:32], s[b][63:32]};
                    r[b+1] = {s[b+1][63:32], s[b+1][63:32]};
                end
                svfu_pkg::OP_LDDQU:
                begin
                    r[b]   = s[b];
                    r[b+1] = s[b+1];
                end
                svfu_pkg::OP_HADDPD:
                begin
                    r[b]   = dbl_addsub(v[b+1], v[b], 1'b0);
                    r[b+1] = dbl_addsub(s[b+1], s[b], 1'b0);
                end
                svfu_pkg::OP_HADDPS:
                begin
                    r[b]   = {sgl_addsub(v[b+1][63:32], v[b+1][31:0], 1'b0),
                              sgl_addsub(v[b][63:32], v[b][31:0], 1'b0)};
                    r[b+1] = {sgl_addsub(s[b+1][63:32], s[b+1][31:0], 1'b0),
                              sgl_addsub(s[b][63:32], s[b][31:0], 1'b0)};
                end
                svfu_pkg::OP_HSUBPD:
                begin
                    r[b]   = dbl_addsub(v[b], v[b+1], 1'b1);
                    r[b+1] = dbl_addsub(s[b], s[b+1], 1'b1);
                end
                svfu_pkg::OP_HSUBPS:
                begin
                    r[b]   = {sgl_addsub(v[b+1][31:0], v[b+1][63:32], 1'b1),
                              sgl_addsub(v[b][31:0], v[b][63:32], 1'b1)};
                    r[b+1] = {sgl_addsub(s[b+1][31:0], s[b+1][63:32], 1'b1),
                              sgl_addsub(s[b][31:0], s[b][63:32], 1'b1)};
                end
                svfu_pkg::OP_ADDSUBPD:
                begin
                    r[b]   = dbl_addsub(v[b], s[b], 1'b1);
                    r[b+1] = dbl_addsub(v[b+1], s[b+1], 1'b0);
                end
                svfu_pkg::OP_ADDSUBPS:
                begin
                    r[b]   = {sgl_addsub(v[b][63:32], s[b][63:32], 1'b0),
                              sgl_addsub(v[b][31:0], s[b][31:0], 1'b1)};
                    r[b+1] = {sgl_addsub(v[b+1][63:32], s[b+1][63:32], 1'b0),
                              sgl_addsub(v[b+1][31:0], s[b+1][31:0], 1'b1)};
                end
                default: ;
            endcase
        end
        o.result_lane0 = r[0];
        o.result_lane1 = r[1];
        o.result_lane2 = r[2];
        o.result_lane3 = r[3];
        o.dest_out     = w.dest_reg;
        o.wide_out     = w.wide;
        return o;
    endfunction

    // ---------------- operand generation ----------------
    function automatic logic [63:0] rand_dbl();
        logic [63:0] sp [11];
        sp = '{64'h0, 64'h8000000000000000, 64'h7FF0000000000000, 64'hFFF0000000000000,
               64'h7FF8000000000000, 64'h7FF0000000000001, 64'h0000000000000001,
               64'h000FFFFFFFFFFFFF, 64'h0010000000000000, 64'h7FEFFFFFFFFFFFFF,
               64'h3FF0000000000000};
        case ($urandom_range(0, 5))
            0: return sp[$urandom_range(0, 10)];
            1: return {$urandom, $urandom};
            default: return {1'($urandom), 11'($urandom_range(1000, 1046)),
                             20'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_sgl();
        logic [31:0] sp [11];
        sp = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
               32'h7F800001, 32'h00000001, 32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF,
               32'h3F800000};
        case ($urandom_range(0, 5))
            0: return sp[$urandom_range(0, 10)];
            1: return $urandom;
            default: return {1'($urandom), 8'($urandom_range(115, 140)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] rand_lane(input logic [3:0] opc);
        if (opc inside {svfu_pkg::OP_HADDPD, svfu_pkg::OP_HSUBPD, svfu_pkg::OP_ADDSUBPD})
            return rand_dbl();
        if (opc inside {svfu_pkg::OP_HADDPS, svfu_pkg::OP_HSUBPS, svfu_pkg::OP_ADDSUBPS})
            return {rand_sgl(), rand_sgl()};
        return {$urandom, $urandom};
    endfunction

    function automatic svfu_pkg::in_item_t rand_word();
        svfu_pkg::in_item_t w;
        w.operation = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                   : 4'($urandom_range(0, 9));
        w.wide       = 1'($urandom);
        w.dest_reg   = 4'($urandom);
        w.src_lane0  = rand_lane(w.operation);
        w.src_lane1  = rand_lane(w.operation);
        w.src_lane2  = rand_lane(w.operation);
        w.src_lane3  = rand_lane(w.operation);
        w.vsrc_lane0 = rand_lane(w.operation);
        w.vsrc_lane1 = rand_lane(w.operation);
        w.vsrc_lane2 = rand_lane(w.operation);
        w.vsrc_lane3 = rand_lane(w.operation);
        // equal operands now and then so that sums cancel exactly
        if ($urandom_range(0, 7) == 0)
        begin
            w.src_lane0 = w.vsrc_lane0;
            w.src_lane1 = w.vsrc_lane1 ^ 64'h8000000080000000;
            w.src_lane2 = w.vsrc_lane2;
        end
        return w;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
        return $urandom_range(0, 2);
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            in_item <= '0;
        end
        else if (!(push && full))
        begin
            if (push)
            begin
                svfu_pkg::out_item_t o;
                bit                  ok;
                o = vector_result(in_item, ok);
                if (ok) expected_results.push_back(o);
                issued++;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (pending_words.size() == 0 ||
                     (issued == PAUSE_AT && (expected_results.size() != 0 || !empty)))
                push <= 1'b0;
            else
            begin
                in_item <= pending_words.pop_front();
                push    <= 1'b1;
                // stretches with no idling between the gappy ones
                send_gap = ((issued / 64) % 3 == 1) ? 0 : rand_gap();
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected word, dest", 64'(out_item.dest_out), 64'd0);
                end
                else
                begin
                    svfu_pkg::out_item_t e;
                    e = expected_results.pop_front();
                    if (out_item.result_lane0 !== e.result_lane0)
                        report_mismatch("lane0", out_item.result_lane0, e.result_lane0);
                    if (out_item.result_lane1 !== e.result_lane1)
                        report_mismatch("lane1", out_item.result_lane1, e.result_lane1);
                    if (out_item.result_lane2 !== e.result_lane2)
                        report_mismatch("lane2", out_item.result_lane2, e.result_lane2);
                    if (out_item.result_lane3 !== e.result_lane3)
                        report_mismatch("lane3", out_item.result_lane3, e.result_lane3);
                    if (out_item.dest_out !== e.dest_out)
                        report_mismatch("dest", 64'(out_item.dest_out), 64'(e.dest_out));
                    if (out_item.wide_out !== e.wide_out)
                        report_mismatch("wide", 64'(out_item.wide_out), 64'(e.wide_out));
                end
            end
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0 && (issued / 80) % 3 != 2)
                    pop_gap = rand_gap();
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial
    begin
        svfu_pkg::in_item_t w;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every opcode at both widths, special operands for hsub and addsub
        for (int op = 0; op <= 9; op++)
            for (int wd = 0; wd < 2; wd++)
            begin
                w = rand_word();
                w.operation = 4'(op);
                w.wide      = 1'(wd);
                w.dest_reg  = 4'(op + wd);
                if (op == svfu_pkg::OP_HSUBPD || op == svfu_pkg::OP_ADDSUBPD)
                begin
                    // +inf in vsrc lanes 0 to 2, nan in src lanes 0 and 1, -inf in src lane 2
                    w.vsrc_lane0 = 64'h7FF0000000000000;
                    w.vsrc_lane1 = 64'h7FF0000000000000;
                    w.src_lane0  = 64'h7FF0000000000001;
                    w.src_lane1  = 64'hFFF4000000000000;
                    w.vsrc_lane2 = 64'h7FF0000000000000;
                    w.src_lane2  = 64'hFFF0000000000000;
                end
                if (op == svfu_pkg::OP_HSUBPS || op == svfu_pkg::OP_ADDSUBPS)
                begin
                    w.vsrc_lane0 = 64'h7F8000007F800000;
                    w.src_lane0  = 64'hFF8000007F800000;
                    w.src_lane1  = 64'h7FA00001FF800001;
                    w.vsrc_lane1 = 64'h0000000180000001;
                end
                pending_words.push_back(w);
            end
        w = '1;
        pending_words.push_back(w);
        w = '0;
        w.operation = 4'd10;
        pending_words.push_back(w);
        w = '0;
        w.operation = svfu_pkg::OP_HADDPD;
        pending_words.push_back(w);

        for (int i = 0; i < RANDOM_WORDS; i++)
            pending_words.push_back(rand_word());

        wait (pending_words.size() == 0);
        @(posedge clk);
        while (push) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/svfu_pkg.sv
design/svfu_front.sv
design/svfu_queue.sv
design/svfu_back.sv
design/sse3_vector_float_unit_top.sv
bench/tb_sse3_vector_float_unit_top.sv
